// ----- rtl/drps_pkg.sv -----
// shared types and constants for the track packet scheduler
package drps_pkg;

    // table size default
    localparam int TABLE_DEPTH = 16;

    // framing constants
    localparam logic [7:0] PRE_MAIN  = 8'd14;
    localparam logic [7:0] PRE_PROG  = 8'd20;
    localparam logic [2:0] MAX_BYTES = 3'd5;
    localparam logic [2:0] REF_BYTES = 3'd2;
    localparam logic [2:0] IDLE_BYTES = 3'd3;

    // idle packet bytes
    localparam logic [7:0] IDLE_BYTE0 = 8'hFF;
    localparam logic [7:0] IDLE_BYTE1 = 8'h00;
    localparam logic [7:0] IDLE_BYTE2 = 8'hFF;

    // slot function codes
    localparam logic FUNC_CMD   = 1'b0;
    localparam logic FUNC_EMPTY = 1'b1;

    // word counts
    localparam logic [1:0] ONE_WORD  = 2'd1;
    localparam logic [1:0] TWO_WORDS = 2'd2;

    // input word
    typedef struct packed {
        logic       func;
        logic [2:0] cmd_length;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
    } t_cmd_word;

    // output word
    typedef struct packed {
        logic [63:0] packet_word;
        logic [1:0]  word_count;
    } t_pkt_word;

endpackage

// ----- rtl/drps_if.sv -----
// valid/ready channel interfaces for command and packet words
interface drps_cmd_if;
    logic                valid;
    logic                ready;
    drps_pkg::t_cmd_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface drps_pkt_if;
    logic                valid;
    logic                ready;
    drps_pkg::t_pkt_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/dcc_refresh_packet_scheduler.sv -----
// track packet scheduler: locomotive table, refresh rotation and packet framing
//
// i_cmd carries one word per packet slot. A command slot (func 0) looks up
// byte0 in the locomotive table, one entry at a time through a single
// registered memory read port and one byte comparator; the speed is updated
// on a match, else the entry is appended while there is room. An empty slot
// (func 1) reads the next entry in round-robin order, or uses the idle packet
// when the table is empty. Framing then runs through a byte shift and XOR
// unit. o_pkt carries the framed 64-bit word and its word count. One slot is
// worked on at a time; i_cmd.ready is high only while the sequencer is idle.
// The finished word sits in an output register, so the next slot is taken
// while it waits; if o_pkt is stalled, the following result waits in the
// sequencer and i_cmd.ready stays low. i_cfg_we writes the main_track bit,
// which is used when a word is framed. Reset clears the entry count, the
// refresh pointer and the output valid, and sets main_track; table contents
// are not cleared and are never read before they are written.
module dcc_refresh_packet_scheduler #(
    parameter int TABLE_DEPTH = drps_pkg::TABLE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    drps_cmd_if.sink          i_cmd,
    drps_pkt_if.source        o_pkt
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_ADD,
        S_REF,
        S_REFD,
        S_FRAME,
        S_DONE
    } t_state;

    // control registers
    t_state              r_state,     n_state;
    logic [CNT_W-1:0]    r_count,     n_count;
    logic [IDX_W-1:0]    r_refresh,   n_refresh;
    logic [IDX_W-1:0]    r_idx,       n_idx;
    logic                r_found,     n_found;
    logic [2:0]          r_step,      n_step;
    logic                r_out_valid, n_out_valid;
    logic                r_main;

    // payload registers
    logic [39:0]         r_src,       n_src;
    logic [2:0]          r_len,       n_len;
    logic [7:0]          r_sum,       n_sum;
    logic [47:0]         r_acc,       n_acc;
    drps_pkg::t_pkt_word r_pkt,       n_pkt;

    // table memory: {address, speed}
    logic [15:0]         mem [TABLE_DEPTH];
    logic [15:0]         r_rd_data;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [15:0]         wr_data;

    logic [7:0]          frame_byte;
    logic [2:0]          cmd_len;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_pkt.valid = r_out_valid;
    assign o_pkt.data  = r_pkt;

    // clamp oversized lengths
    assign cmd_len = (i_cmd.data.cmd_length > drps_pkg::MAX_BYTES) ?
                     drps_pkg::MAX_BYTES : i_cmd.data.cmd_length;

    // byte fed into the framing shift: data, then checksum, then zero fill
    always_comb begin
        if (r_step < r_len) begin
            frame_byte = r_src[39:32];
        end else if (r_step == r_len) begin
            frame_byte = r_sum;
        end else begin
            frame_byte = 8'd0;
        end
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_refresh   = r_refresh;
        n_idx       = r_idx;
        n_found     = r_found;
        n_step      = r_step;
        n_src       = r_src;
        n_len       = r_len;
        n_sum       = r_sum;
        n_acc       = r_acc;
        n_pkt       = r_pkt;
        n_out_valid = r_out_valid;
        rd_addr     = r_idx;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = r_src[39:24];

        if (r_out_valid && o_pkt.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_src   = {i_cmd.data.byte0, i_cmd.data.byte1, i_cmd.data.byte2,
                               i_cmd.data.byte3, i_cmd.data.byte4};
                    n_len   = cmd_len;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_sum   = 8'd0;
                    n_step  = 3'd0;
                    n_acc   = '0;
                    if (i_cmd.data.func == drps_pkg::FUNC_CMD) begin
                        n_state = (r_count == '0) ? S_ADD : S_SCAN;
                    end else if (r_count == '0) begin
                        n_src   = {drps_pkg::IDLE_BYTE0, drps_pkg::IDLE_BYTE1,
                                   drps_pkg::IDLE_BYTE2, 16'd0};
                        n_len   = drps_pkg::IDLE_BYTES;
                        n_state = S_FRAME;
                    end else begin
                        // stale pointer restarts at the first entry
                        n_idx   = (CNT_W'(r_refresh) >= r_count) ? '0 : r_refresh;
                        n_state = S_REF;
                    end
                end
            end
            S_SCAN: begin
                rd_addr = r_idx;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_rd_data[15:8] == r_src[39:32]) begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    n_found = 1'b1;
                end
                if (CNT_W'(r_idx) + CNT_W'(1) >= r_count) begin
                    n_state = S_ADD;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_SCAN;
                end
            end
            S_ADD: begin
                if (!r_found && r_count < CNT_W'(TABLE_DEPTH)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_count[IDX_W-1:0];
                    n_count = r_count + CNT_W'(1);
                    if (r_count == '0) begin
                        n_refresh = '0;
                    end
                end
                n_state = S_FRAME;
            end
            S_REF: begin
                rd_addr = r_idx;
                n_state = S_REFD;
            end
            S_REFD: begin
                n_src   = {r_rd_data, 24'd0};
                n_len   = drps_pkg::REF_BYTES;
                n_refresh = (CNT_W'(r_idx) + CNT_W'(1) >= r_count) ?
                            '0 : r_idx + IDX_W'(1);
                n_state = S_FRAME;
            end
            S_FRAME: begin
                n_acc  = {r_acc[39:0], frame_byte};
                if (r_step < r_len) begin
                    n_sum = r_sum ^ r_src[39:32];
                end
                n_src  = {r_src[31:0], 8'd0};
                n_step = r_step + 3'd1;
                if (r_step == drps_pkg::MAX_BYTES) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_pkt.ready) begin
                    n_out_valid = 1'b1;
                    n_pkt.packet_word = {r_main ? drps_pkg::PRE_MAIN : drps_pkg::PRE_PROG,
                                         8'(r_len) + 8'd1, r_acc};
                    n_pkt.word_count  = (r_len >= drps_pkg::REF_BYTES) ?
                                        drps_pkg::TWO_WORDS : drps_pkg::ONE_WORD;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_refresh   <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
            r_main      <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_refresh   <= n_refresh;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_main <= i_cfg_data;
            end
        end
        r_src <= n_src;
        r_len <= n_len;
        r_sum <= n_sum;
        r_acc <= n_acc;
        r_pkt <= n_pkt;
    end

    // locomotive table, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

endmodule
